// File: design/lqiac_pkg.sv
// ----------------------------------------------------------------------------
// lqiac_pkg: shared definitions for the three-axis LQI attitude control core
// Widths, register indices, gain reset values and the axis control struct.
// ----------------------------------------------------------------------------
package lqiac_pkg;

	localparam int NumRegs  = 8;
	localparam int RegIdxW  = 3;
	localparam int GainW    = 16;
	localparam int AngleW   = 16;
	localparam int DtW      = 16;
	localparam int ThrW     = 12;
	localparam int TorqueW  = 40;
	localparam int IntegW   = 48;

	typedef logic [GainW-1:0]          gain_t;
	typedef logic signed [AngleW-1:0]  angle_t;
	typedef logic [DtW-1:0]            dt_t;
	typedef logic [ThrW-1:0]           throttle_t;
	typedef logic signed [TorqueW-1:0] torque_t;
	typedef logic signed [IntegW-1:0]  integ_t;
	typedef logic [RegIdxW-1:0]        reg_idx_t;

	localparam reg_idx_t REG_KI_ROLL_PITCH = 3'd0;
	localparam reg_idx_t REG_KI_YAW        = 3'd1;
	localparam reg_idx_t REG_KP_ROLL       = 3'd2;
	localparam reg_idx_t REG_KP_PITCH      = 3'd3;
	localparam reg_idx_t REG_KP_YAW        = 3'd4;
	localparam reg_idx_t REG_KD_ROLL       = 3'd5;
	localparam reg_idx_t REG_KD_PITCH      = 3'd6;
	localparam reg_idx_t REG_KD_YAW        = 3'd7;

	localparam gain_t GAIN_RESET [NumRegs] = '{
		16'd3686, 16'd664, 16'd24494, 16'd24535,
		16'd14746, 16'd14623, 16'd14664, 16'd6554
	};

	localparam throttle_t THROTTLE_ON = 12'd1020;

	typedef struct packed {
		logic load_s2;
		logic load_out;
	} axis_ctrl_t;

endpackage

// File: design/lqiac_in_if.sv
// ----------------------------------------------------------------------------
// lqiac_in_if: measurement channel
// Valid/ready channel carrying references, angles, rates, time step, throttle.
// ----------------------------------------------------------------------------
interface lqiac_in_if ();
	logic                  valid;
	logic                  ready;
	lqiac_pkg::angle_t     ref_roll;
	lqiac_pkg::angle_t     ref_pitch;
	lqiac_pkg::angle_t     ref_yaw;
	lqiac_pkg::angle_t     angle_roll;
	lqiac_pkg::angle_t     angle_pitch;
	lqiac_pkg::angle_t     angle_yaw;
	lqiac_pkg::angle_t     rate_roll;
	lqiac_pkg::angle_t     rate_pitch;
	lqiac_pkg::angle_t     rate_yaw;
	lqiac_pkg::dt_t        time_step;
	lqiac_pkg::throttle_t  throttle;

	modport source (
		output valid, ref_roll, ref_pitch, ref_yaw, angle_roll, angle_pitch, angle_yaw,
		output rate_roll, rate_pitch, rate_yaw, time_step, throttle,
		input  ready
	);
	modport sink (
		input  valid, ref_roll, ref_pitch, ref_yaw, angle_roll, angle_pitch, angle_yaw,
		input  rate_roll, rate_pitch, rate_yaw, time_step, throttle,
		output ready
	);
endinterface

// File: design/lqiac_out_if.sv
// ----------------------------------------------------------------------------
// lqiac_out_if: torque command channel
// Valid/ready channel carrying the three torques and the motor enable flag.
// ----------------------------------------------------------------------------
interface lqiac_out_if ();
	logic               valid;
	logic               ready;
	lqiac_pkg::torque_t torque_roll;
	lqiac_pkg::torque_t torque_pitch;
	lqiac_pkg::torque_t torque_yaw;
	logic               motors_enabled;

	modport source (
		output valid, torque_roll, torque_pitch, torque_yaw, motors_enabled,
		input  ready
	);
	modport sink (
		input  valid, torque_roll, torque_pitch, torque_yaw, motors_enabled,
		output ready
	);
endinterface

// File: design/lqiac_axis.sv
// ----------------------------------------------------------------------------
// lqiac_axis: one axis of the attitude controller
// Forms the products from the stage-one item, keeps the saturating integral,
// then sums and saturates the torque into the output register.
// ----------------------------------------------------------------------------
module lqiac_axis (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lqiac_pkg::axis_ctrl_t  ctrl,
	input  lqiac_pkg::angle_t      ref_angle,
	input  lqiac_pkg::angle_t      meas_angle,
	input  lqiac_pkg::angle_t      rate,
	input  lqiac_pkg::dt_t         time_step,
	input  lqiac_pkg::gain_t       ki,
	input  lqiac_pkg::gain_t       kp,
	input  lqiac_pkg::gain_t       kd,
	output lqiac_pkg::torque_t     torque
);

	logic signed [16:0] err;
	logic signed [33:0] kp_prod;
	logic signed [32:0] kd_prod;
	logic signed [33:0] step_prod;
	logic signed [40:0] ki_hi_prod;
	logic        [39:0] ki_lo_prod;
	logic signed [48:0] integ_sum;
	lqiac_pkg::integ_t  integ_next;
	lqiac_pkg::integ_t  integ_q;

	logic signed [33:0] kp_s2;
	logic signed [32:0] kd_s2;
	logic signed [40:0] ki_hi_s2;
	logic        [19:0] ki_lo_s2;

	logic signed [44:0] iterm;
	logic signed [45:0] tq_sum;
	lqiac_pkg::torque_t tq_sat;
	lqiac_pkg::torque_t torque_q;

	assign err        = {ref_angle[15], ref_angle} - {meas_angle[15], meas_angle};
	assign kp_prod    = $signed({1'b0, kp}) * err;
	assign kd_prod    = $signed({1'b0, kd}) * rate;
	assign step_prod  = err * $signed({1'b0, time_step});
	assign ki_hi_prod = $signed({1'b0, ki}) * $signed(integ_q[47:24]);
	assign ki_lo_prod = ki * integ_q[23:0];
	assign integ_sum  = {integ_q[47], integ_q} + {{15{step_prod[33]}}, step_prod};

	always_comb begin
		if (integ_sum[48] != integ_sum[47]) begin
			integ_next = integ_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			integ_next = integ_sum[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (ctrl.load_s2) begin
			integ_q <= integ_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			kp_s2    <= kp_prod;
			kd_s2    <= kd_prod;
			ki_hi_s2 <= ki_hi_prod;
			ki_lo_s2 <= ki_lo_prod[39:20];
		end
	end

	// The low partial product is non-negative, so flooring it alone is exact.
	assign iterm  = {ki_hi_s2, 4'd0} + $signed({25'd0, ki_lo_s2});
	assign tq_sum = {iterm[44], iterm} + {{12{kp_s2[33]}}, kp_s2}
		- {{13{kd_s2[32]}}, kd_s2};

	always_comb begin
		if (tq_sum[45:39] != {7{tq_sum[45]}}) begin
			tq_sat = tq_sum[45] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
		end else begin
			tq_sat = tq_sum[39:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			torque_q <= tq_sat;
		end
	end

	assign torque = torque_q;

endmodule

// File: design/three_axis_lqi_attitude_control_core.sv
// ----------------------------------------------------------------------------
// three_axis_lqi_attitude_control_core: LQI attitude controller, three axes
//
// The sensor channel takes one transaction per control update: references,
// measured angles and rates for roll, pitch and yaw, the time step and the
// throttle. Each accepted transaction produces exactly one transaction on the
// actuator channel with the three saturated torques and the motor enable.
// The user sets the gains through the write port (wr_en, wr_index, wr_data)
// only while the core is idle, which the core does not enforce; they take
// their nominal values at reset. The transaction passes an input register, a
// product register and the output register before the result is valid. A new
// transaction is accepted every cycle while the pipeline is not full; the
// integral is updated as an item leaves stage one. Reset clears the three
// integrals, empties the pipeline and restores the gains. When the receiver
// stalls, the result holds in the output register and the stages behind it
// keep filling, so sensor.ready only falls once all three stages hold a
// transaction.
// ----------------------------------------------------------------------------
module three_axis_lqi_attitude_control_core (
	input  logic                  clk,
	input  logic                  arst_n,
	lqiac_in_if.sink              sensor,
	lqiac_out_if.source           actuator,
	input  logic                  wr_en,
	input  lqiac_pkg::reg_idx_t   wr_index,
	input  lqiac_pkg::gain_t      wr_data
);

	lqiac_pkg::gain_t       gain_q [lqiac_pkg::NumRegs];
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   out_valid_q;
	logic                   en_s1;
	logic                   en_s2;
	logic                   en_out;
	lqiac_pkg::angle_t      ref_s1   [3];
	lqiac_pkg::angle_t      angle_s1 [3];
	lqiac_pkg::angle_t      rate_s1  [3];
	lqiac_pkg::dt_t         dt_s1;
	logic                   motors_s1;
	logic                   motors_s2;
	logic                   motors_q;
	lqiac_pkg::gain_t       ki_ax [3];
	lqiac_pkg::gain_t       kp_ax [3];
	lqiac_pkg::gain_t       kd_ax [3];
	lqiac_pkg::torque_t     torque_ax [3];
	lqiac_pkg::axis_ctrl_t  ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lqiac_pkg::NumRegs; i++) begin
				gain_q[i] <= lqiac_pkg::GAIN_RESET[i];
			end
		end else if (wr_en) begin
			gain_q[wr_index] <= wr_data;
		end
	end

	assign en_out = !out_valid_q || actuator.ready;
	assign en_s2  = !valid_s2 || en_out;
	assign en_s1  = !valid_s1 || en_s2;
	assign sensor.ready = en_s1;

	assign ctrl.load_s2  = valid_s1 && en_s2;
	assign ctrl.load_out = valid_s2 && en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= sensor.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && en_s1) begin
			ref_s1[0]   <= sensor.ref_roll;
			ref_s1[1]   <= sensor.ref_pitch;
			ref_s1[2]   <= sensor.ref_yaw;
			angle_s1[0] <= sensor.angle_roll;
			angle_s1[1] <= sensor.angle_pitch;
			angle_s1[2] <= sensor.angle_yaw;
			rate_s1[0]  <= sensor.rate_roll;
			rate_s1[1]  <= sensor.rate_pitch;
			rate_s1[2]  <= sensor.rate_yaw;
			dt_s1       <= sensor.time_step;
			motors_s1   <= sensor.throttle > lqiac_pkg::THROTTLE_ON;
		end
		if (ctrl.load_s2) begin
			motors_s2 <= motors_s1;
		end
		if (ctrl.load_out) begin
			motors_q <= motors_s2;
		end
	end

	assign ki_ax[0] = gain_q[lqiac_pkg::REG_KI_ROLL_PITCH];
	assign ki_ax[1] = gain_q[lqiac_pkg::REG_KI_ROLL_PITCH];
	assign ki_ax[2] = gain_q[lqiac_pkg::REG_KI_YAW];
	assign kp_ax[0] = gain_q[lqiac_pkg::REG_KP_ROLL];
	assign kp_ax[1] = gain_q[lqiac_pkg::REG_KP_PITCH];
	assign kp_ax[2] = gain_q[lqiac_pkg::REG_KP_YAW];
	assign kd_ax[0] = gain_q[lqiac_pkg::REG_KD_ROLL];
	assign kd_ax[1] = gain_q[lqiac_pkg::REG_KD_PITCH];
	assign kd_ax[2] = gain_q[lqiac_pkg::REG_KD_YAW];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		lqiac_axis u_axis (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.ref_angle  (ref_s1[a]),
			.meas_angle (angle_s1[a]),
			.rate       (rate_s1[a]),
			.time_step  (dt_s1),
			.ki         (ki_ax[a]),
			.kp         (kp_ax[a]),
			.kd         (kd_ax[a]),
			.torque     (torque_ax[a])
		);
	end

	assign actuator.valid          = out_valid_q;
	assign actuator.torque_roll    = torque_ax[0];
	assign actuator.torque_pitch   = torque_ax[1];
	assign actuator.torque_yaw     = torque_ax[2];
	assign actuator.motors_enabled = motors_q;

endmodule

// File: design/lqiac_checker.sv
// ----------------------------------------------------------------------------
// lqiac_checker: port-level checks for the attitude control core
// Output handshake rules, pipeline latency and back-pressure behaviour.
// ----------------------------------------------------------------------------
module lqiac_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input lqiac_pkg::torque_t torque_roll,
	input lqiac_pkg::torque_t torque_pitch,
	input lqiac_pkg::torque_t torque_yaw,
	input logic               motors_enabled
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction withdrawn before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(torque_roll) && $stable(torque_pitch)
			&& $stable(torque_yaw) && $stable(motors_enabled))
		else $error("stalled result changed");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result not delivered three cycles after acceptance");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused while the output is free");

endmodule

bind three_axis_lqi_attitude_control_core lqiac_checker u_lqiac_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (sensor.valid),
	.in_ready       (sensor.ready),
	.out_valid      (actuator.valid),
	.out_ready      (actuator.ready),
	.torque_roll    (actuator.torque_roll),
	.torque_pitch   (actuator.torque_pitch),
	.torque_yaw     (actuator.torque_yaw),
	.motors_enabled (actuator.motors_enabled)
);
